// ===== sv/y86ms_pkg.sv =====
// Package for the Y86 pipeline memory stage: opcodes, status codes,
// register codes and stream widths. No dependencies.
package y86ms_pkg;

  // Default data memory size in bytes
  localparam int unsigned MemBytesDefault = 4096;

  // Instruction codes that matter to this stage
  localparam logic [3:0] OP_NOP    = 4'h1;
  localparam logic [3:0] OP_RMMOVL = 4'h4;
  localparam logic [3:0] OP_MRMOVL = 4'h5;
  localparam logic [3:0] OP_CALL   = 4'h8;
  localparam logic [3:0] OP_RET    = 4'h9;
  localparam logic [3:0] OP_PUSHL  = 4'hA;
  localparam logic [3:0] OP_POPL   = 4'hB;

  // Status codes
  localparam logic [1:0] ST_AOK = 2'd0;
  localparam logic [1:0] ST_ADR = 2'd2;

  // No destination register
  localparam logic [3:0] REG_NONE = 4'hF;

  // Stream payload widths (whole bytes)
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 112;

endpackage

// ===== sv/y86_pipeline_memory_stage_core.sv =====
// Memory stage of a pipelined Y86 core: decode, word access to the data
// memory, sticky write blocking and the output register.
// Depends on y86ms_pkg and y86ms_bank.

// The stage takes one execute-to-memory item per clock when ready (clear
// done, output side not stalling) and returns one result item per item
// through the read stage register and the output register. Data memory is
// byte addressed and split into four byte-wide banks (byte a lives in bank
// a%4, row a/4), so an unaligned 32-bit word is one read or one write per
// bank in a single cycle. Loads and stores of consecutive items need no
// forwarding: a store is written at its acceptance edge, and a later load
// reads the banks at its own, later acceptance edge. After reset the stage
// zeroes the memory, one row of all four banks per cycle, over all
// (MemBytes+3)/4 rows; no item is accepted until that ends. A sticky flag
// blocks stores after an incoming exception status or an address fault; a
// bubble item re-enables stores. Backpressure on the output stalls the
// stage without losing the item held in the read stage.
module y86_pipeline_memory_stage_core #(
  parameter int unsigned MemBytes = y86ms_pkg::MemBytesDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [1:0] in_status, [5:2] opcode, [6] cond_taken, [38:7] exec_value,
  // [70:39] src_value, [74:71] dest_exec, [78:75] dest_mem,
  // [80:79] wb_status, [87:81] zero
  input  logic [y86ms_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] bubble
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] out_status, [33:2] mem_value, [65:34] fwd_exec_value,
  // [97:66] fwd_src_value, [101:98] fwd_opcode, [102] fwd_cond,
  // [106:103] fwd_dest_exec, [110:107] fwd_dest_mem, [111] wb_load
  output logic [y86ms_pkg::OutDataW-1:0]     m_axis_tdata
);

  localparam int unsigned Rows = (MemBytes + 3) / 4;
  localparam int unsigned RowW = $clog2(Rows);
  localparam logic [32:0] MemLimit = 33'(MemBytes);
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);

  // Item held while the bank reads complete
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  opcode;
    logic        cond;
    logic [31:0] exec_value;
    logic [31:0] src_value;
    logic [3:0]  dest_exec;
    logic [3:0]  dest_mem;
    logic        wb_load;
    logic        rd;
    logic        addr_ok;
    logic [1:0]  byte_off;
  } s1_item_t;

  // ---------------------------------------------------------------------
  // Input unpacking and bubble substitution
  // ---------------------------------------------------------------------
  logic        bubble;
  logic [1:0]  in_status, wb_status;
  logic [3:0]  opcode, dest_exec, dest_mem;
  logic        cond_taken;
  logic [31:0] exec_value, src_value;

  assign bubble     = s_axis_tuser[0];
  assign in_status  = s_axis_tdata[1:0];
  assign opcode     = s_axis_tdata[5:2];
  assign cond_taken = s_axis_tdata[6];
  assign exec_value = s_axis_tdata[38:7];
  assign src_value  = s_axis_tdata[70:39];
  assign dest_exec  = s_axis_tdata[74:71];
  assign dest_mem   = s_axis_tdata[78:75];
  assign wb_status  = s_axis_tdata[80:79];

  logic [1:0]  status_e;
  logic [3:0]  op_e, dste_e, dstm_e;
  logic        cond_e;
  logic [31:0] vale_e, vala_e;

  assign status_e = bubble ? y86ms_pkg::ST_AOK   : in_status;
  assign op_e     = bubble ? y86ms_pkg::OP_NOP   : opcode;
  assign cond_e   = bubble ? 1'b0                : cond_taken;
  assign vale_e   = bubble ? 32'd0               : exec_value;
  assign vala_e   = bubble ? 32'd0               : src_value;
  assign dste_e   = bubble ? y86ms_pkg::REG_NONE : dest_exec;
  assign dstm_e   = bubble ? y86ms_pkg::REG_NONE : dest_mem;

  // ---------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------
  logic rd, wr, use_vala;

  always_comb begin
    rd       = 1'b0;
    wr       = 1'b0;
    use_vala = 1'b0;
    unique case (op_e) inside
      y86ms_pkg::OP_MRMOVL: begin
        rd = 1'b1;
      end
      y86ms_pkg::OP_POPL, y86ms_pkg::OP_RET: begin
        rd       = 1'b1;
        use_vala = 1'b1;
      end
      y86ms_pkg::OP_RMMOVL, y86ms_pkg::OP_PUSHL, y86ms_pkg::OP_CALL: begin
        wr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic [31:0] addr;
  logic        addr_ok;

  assign addr    = use_vala ? vala_e : vale_e;
  // Word must fit entirely: addr + 4 <= MemBytes, without wraparound
  assign addr_ok = ({1'b0, addr} + 33'd4) <= MemLimit;

  // ---------------------------------------------------------------------
  // Write blocking flag and fault
  // ---------------------------------------------------------------------
  logic wflag_q, wflag_d;
  logic flag_eff, wr_go, wr_en, fault;
  logic clr_busy_q, clr_busy_d;
  logic [RowW-1:0] clr_cnt_q, clr_cnt_d;
  logic s1_valid_q, s1_valid_d, s2_valid_q, s2_valid_d;
  logic s2_free, s1_adv, acc;

  // bubble re-enables, any exception status blocks, own write included
  assign flag_eff = (bubble | wflag_q) & (status_e == y86ms_pkg::ST_AOK);
  assign wr_go    = wr & flag_eff;
  assign wr_en    = wr_go & addr_ok;
  // blocked stores are not range-checked
  assign fault    = (rd | wr_go) & ~addr_ok;

  assign s2_free       = ~s2_valid_q | m_axis_tready;
  assign s1_adv        = s1_valid_q & s2_free;
  assign s_axis_tready = ~clr_busy_q & (~s1_valid_q | s2_free);
  assign acc           = s_axis_tvalid & s_axis_tready;

  assign wflag_d    = acc ? (flag_eff & ~fault) : wflag_q;
  assign s1_valid_d = acc | (s1_valid_q & ~s1_adv);
  assign s2_valid_d = s1_adv | (s2_valid_q & ~m_axis_tready);

  // Clearing pass after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_cnt_d  = clr_cnt_q;
    if (clr_busy_q) begin
      if (clr_cnt_q == LastRow) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_cnt_d = clr_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wflag_q    <= 1'b1;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      wflag_q    <= wflag_d;
      clr_busy_q <= clr_busy_d;
      clr_cnt_q  <= clr_cnt_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  // ---------------------------------------------------------------------
  // Byte banks: bank k holds bytes with address % 4 == k
  // ---------------------------------------------------------------------
  logic [RowW-1:0] row_base;
  logic [1:0]      byte_off;
  logic [7:0]      rdata [4];

  assign row_base = addr[RowW+1:2];
  assign byte_off = addr[1:0];

  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [1:0]      lane;   // byte of the word that lands in this bank
    logic [RowW-1:0] row;
    logic [7:0]      wbyte;
    logic            bank_we;
    logic [RowW-1:0] bank_waddr;
    logic [7:0]      bank_wdata;

    assign lane  = 2'(k) - byte_off;
    // banks below the offset hold the bytes that wrapped into the next row
    assign row   = row_base + RowW'(2'(k) < byte_off);
    assign wbyte = vala_e[8*lane +: 8];

    assign bank_we    = clr_busy_q | (acc & wr_en);
    assign bank_waddr = clr_busy_q ? clr_cnt_q : row;
    assign bank_wdata = clr_busy_q ? 8'd0 : wbyte;

    y86ms_bank #(
      .Depth (Rows)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we),
      .waddr_i (bank_waddr),
      .wdata_i (bank_wdata),
      .re_i    (acc & rd),
      .raddr_i (row),
      .rdata_o (rdata[k])
    );
  end

  // ---------------------------------------------------------------------
  // Read stage register
  // ---------------------------------------------------------------------
  s1_item_t s1_q, s1_d;

  always_comb begin
    s1_d.status     = fault ? y86ms_pkg::ST_ADR : status_e;
    s1_d.opcode     = op_e;
    s1_d.cond       = cond_e;
    s1_d.exec_value = vale_e;
    s1_d.src_value  = vala_e;
    s1_d.dest_exec  = dste_e;
    s1_d.dest_mem   = dstm_e;
    s1_d.wb_load    = (wb_status == y86ms_pkg::ST_AOK);
    s1_d.rd         = rd;
    s1_d.addr_ok    = addr_ok;
    s1_d.byte_off   = byte_off;
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
  end

  // Rotate bank outputs back into word order
  logic [31:0] word, mem_value;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      word[8*i +: 8] = rdata[2'(s1_q.byte_off + 2'(i))];
    end
  end

  always_comb begin
    if (s1_q.rd) begin
      mem_value = s1_q.addr_ok ? word : 32'd0;
    end else begin
      mem_value = s1_q.src_value;
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  logic [y86ms_pkg::OutDataW-1:0] s2_q, s2_d;

  assign s2_d = {s1_q.wb_load, s1_q.dest_mem, s1_q.dest_exec, s1_q.cond,
                 s1_q.opcode, s1_q.src_value, s1_q.exec_value, mem_value,
                 s1_q.status};

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_q <= s2_d;
    end
  end

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = s2_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !s_axis_tready)
    else $error("item accepted during memory clear");

  a_fault_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && fault) |=> !wflag_q)
    else $error("write flag still set after address fault");

  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && wr_en) |-> (flag_eff && addr_ok && !clr_busy_q))
    else $error("store issued while blocked or out of range");

  a_s1_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> s1_valid_q)
    else $error("read stage item dropped under backpressure");

endmodule

// ===== sv/y86ms_bank.sv =====
// One byte lane of the data memory: one write port, one read port,
// registered read data. Depends on y86ms_pkg for the default depth.
module y86ms_bank #(
  parameter int unsigned Depth = y86ms_pkg::MemBytesDefault / 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
